/* rtl/iee_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants for the infix expression evaluator
// Request/result payloads, operator codes, character codes.
// ----------------------------------------------------------------------------
package iee_pkg;

	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DIGIT_BASE      = 10;

	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_TIMES  = 8'h2A;
	localparam logic [7:0] CH_DIVIDE = 8'h2F;

	typedef enum logic [1:0] {
		OP_PLUS,
		OP_MINUS,
		OP_TIMES,
		OP_DIVIDE
	} op_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               div_zero;
	} result_t;

	typedef struct packed {
		logic start;
		logic div;
	} mdu_ctrl_t;

endpackage

/* rtl/iee_muldiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_muldiv: iterative multiply / signed divide
// One adder shared by shift-add multiply and restoring divide, one bit per
// cycle. Divide truncates toward zero; the divisor is never zero here.
// ----------------------------------------------------------------------------
module iee_muldiv #(
	parameter int VALUE_WIDTH = iee_pkg::DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iee_pkg::mdu_ctrl_t     ctrl,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] result
);

	localparam int VW = VALUE_WIDTH;
	localparam int CW = $clog2(VW);

	typedef enum logic [1:0] {
		U_IDLE,
		U_RUN,
		U_FIN
	} ustate_t;

	ustate_t         state_q;
	logic [CW-1:0]   cnt_q;
	logic            div_q;
	logic            neg_q;
	logic [VW-1:0]   acc_q;
	logic [VW-1:0]   opnd_q;
	logic [VW-1:0]   shf_q;
	logic            done_q;
	logic [VW-1:0]   result_q;

	logic [VW-1:0]   rem_sh;
	logic [VW-1:0]   add_x;
	logic [VW-1:0]   add_y;
	logic [VW:0]     sum;
	logic [VW-1:0]   mag_a;
	logic [VW-1:0]   mag_b;

	always_comb begin
		rem_sh = {acc_q[VW-2:0], shf_q[VW-1]};
		if (div_q) begin
			add_x = rem_sh;
			add_y = ~opnd_q;
		end else begin
			add_x = acc_q;
			add_y = shf_q[0] ? opnd_q : '0;
		end
		sum   = {1'b0, add_x} + {1'b0, add_y} + (VW+1)'(div_q);
		mag_a = a[VW-1] ? VW'(-a) : a;
		mag_b = b[VW-1] ? VW'(-b) : b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			div_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (ctrl.start) begin
						div_q   <= ctrl.div;
						neg_q   <= a[VW-1] ^ b[VW-1];
						acc_q   <= '0;
						opnd_q  <= ctrl.div ? mag_b : a;
						shf_q   <= ctrl.div ? mag_a : b;
						cnt_q   <= CW'(VW-1);
						state_q <= U_RUN;
					end
				end
				U_RUN: begin
					if (div_q) begin
						acc_q <= sum[VW] ? sum[VW-1:0] : rem_sh;
						shf_q <= {shf_q[VW-2:0], sum[VW]};
					end else begin
						acc_q  <= sum[VW-1:0];
						opnd_q <= {opnd_q[VW-2:0], 1'b0};
						shf_q  <= {1'b0, shf_q[VW-1:1]};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= U_FIN;
				end
				U_FIN: begin
					if (div_q)
						result_q <= neg_q ? VW'(-shf_q) : shf_q;
					else
						result_q <= acc_q;
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* rtl/infix_expression_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator: character-serial + - * / evaluator
// Running total, pending term, number being read and pending operator;
// * and / run on a shared iterative multiply/divide unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  char      in   char_valid / char_stall   char_req (ch, last)
//  result    out  result_valid / result_stall result (value, div_zero)
//
//  Digit, space, or operator/last with + or - pending: one request per cycle.
//  Operator or last with * or / pending: the sequencer waits in S_WAIT for the
//  one-bit-per-cycle multiply/divide unit; divide by zero skips the unit.
//  Request with last: S_FIN then loads the output register, and waits there
//  while a previous result is still stalled in it.
//  Reset clears all but out_q and unit data; char_stall is high when busy.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
	parameter int VALUE_WIDTH = iee_pkg::DEF_VALUE_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  iee_pkg::char_req_t char_req,
	output logic               result_valid,
	input  logic               result_stall,
	output iee_pkg::result_t   result
);

	localparam int VW = VALUE_WIDTH;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [VW-1:0]     total_q;
	logic [VW-1:0]     term_q;
	logic [VW-1:0]     cur_q;
	iee_pkg::op_t      op_q;
	iee_pkg::op_t      nop_q;
	logic              isop_q;
	logic              last_q;
	logic              err_q;
	logic              out_valid_q;
	iee_pkg::result_t  out_q;

	logic              accept;
	logic              is_digit;
	logic              is_op;
	iee_pkg::op_t      new_op;
	logic [VW-1:0]     cur_n;
	logic signed [VW-1:0] final_sum;
	logic              out_free;

	iee_pkg::mdu_ctrl_t mdu_ctrl;
	logic               mdu_done;
	logic [VW-1:0]      mdu_result;

	always_comb begin
		accept   = char_valid && !char_stall;
		is_digit = char_req.ch inside {[iee_pkg::CH_0:iee_pkg::CH_9]};
		is_op    = 1'b1;
		new_op   = iee_pkg::OP_PLUS;
		case (char_req.ch)
			iee_pkg::CH_PLUS:   new_op = iee_pkg::OP_PLUS;
			iee_pkg::CH_MINUS:  new_op = iee_pkg::OP_MINUS;
			iee_pkg::CH_TIMES:  new_op = iee_pkg::OP_TIMES;
			iee_pkg::CH_DIVIDE: new_op = iee_pkg::OP_DIVIDE;
			default:            is_op  = 1'b0;
		endcase
		cur_n = cur_q;
		if (is_digit)
			cur_n = VW'(cur_q * VW'(iee_pkg::DIGIT_BASE)) + VW'(char_req.ch[3:0]);
		mdu_ctrl.start = accept && (is_op || char_req.last) &&
			(op_q == iee_pkg::OP_TIMES || (op_q == iee_pkg::OP_DIVIDE && cur_n != '0));
		mdu_ctrl.div   = (op_q == iee_pkg::OP_DIVIDE);
		final_sum = total_q + term_q;
		out_free  = !(out_valid_q && result_stall);
	end

	iee_muldiv #(
		.VALUE_WIDTH(VW)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mdu_ctrl),
		.a      (term_q),
		.b      (cur_n),
		.done   (mdu_done),
		.result (mdu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			term_q      <= '0;
			cur_q       <= '0;
			op_q        <= iee_pkg::OP_PLUS;
			nop_q       <= iee_pkg::OP_PLUS;
			isop_q      <= 1'b0;
			last_q      <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall && state_q != S_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!(is_op || char_req.last)) begin
							cur_q <= cur_n;
						end else begin
							cur_q <= '0;
							if (mdu_ctrl.start) begin
								nop_q   <= new_op;
								isop_q  <= is_op;
								last_q  <= char_req.last;
								state_q <= S_WAIT;
							end else begin
								case (op_q)
									iee_pkg::OP_PLUS: begin
										total_q <= total_q + term_q;
										term_q  <= cur_n;
									end
									iee_pkg::OP_MINUS: begin
										total_q <= total_q + term_q;
										term_q  <= VW'(-cur_n);
									end
									default: begin
										// divide by zero
										term_q <= '0;
										err_q  <= 1'b1;
									end
								endcase
								if (is_op)
									op_q <= new_op;
								if (char_req.last)
									state_q <= S_FIN;
							end
						end
					end
				end
				S_WAIT: begin
					if (mdu_done) begin
						term_q <= mdu_result;
						if (isop_q)
							op_q <= nop_q;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_q.value    <= 32'(final_sum);
						out_q.div_zero <= err_q;
						out_valid_q    <= 1'b1;
						total_q        <= '0;
						term_q         <= '0;
						cur_q          <= '0;
						op_q           <= iee_pkg::OP_PLUS;
						err_q          <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign char_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_done |-> state_q == S_WAIT)
		else $error("multiply/divide result outside wait state");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_FIN)
		else $error("result loaded without finishing an expression");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=>
		(state_q == S_IDLE && total_q == '0 && term_q == '0 && !err_q))
		else $error("state not cleared after result");

	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_ctrl.start |=> state_q == S_WAIT)
		else $error("unit started without entering wait state");

endmodule

/* tb/infix_expression_evaluator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_tb: self-checking bench for the infix evaluator
// Feeds expressions one character per request, starting with a short table
// of hand-picked cases and then random expressions, mostly well-formed, some
// with noise, leading or repeated operators. A model in the bench tracks the
// total, pending term, number and operator; results are checked in order
// against it or typed rows. Sender bursts, receiver stalls vary throughout.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_tb;
	import iee_pkg::*;

	localparam int          RANDOM_ITEMS = 1350;
	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          DRAIN_CYCLES = 100;
	localparam int          HOLD_START   = 2000;
	localparam int          HOLD_LEN     = 400;
	localparam logic [7:0]  CH_SPACE     = 8'h20;
	localparam logic [7:0]  CH_NOISE     = 8'hFF;
	localparam logic [7:0]  CH_NUL       = 8'h00;

	typedef struct packed {
		logic [7:0]         ch;
		logic               last;
		logic               typed;
		logic signed [31:0] value;
		logic               div_zero;
	} stim_row_t;

	localparam int DIR_ROWS = 20;

	stim_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{CH_SPACE,      1'b1, 1'b1, 32'sd0, 1'b0},
		'{CH_0 + 8'd7,   1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_DIVIDE,     1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_0,          1'b1, 1'b1, 32'sd0, 1'b1},
		'{CH_TIMES,      1'b1, 1'b1, 32'sd0, 1'b0},
		'{CH_0 + 8'd9,   1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_MINUS,      1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_0 + 8'd3,   1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_TIMES,      1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_0 + 8'd2,   1'b1, 1'b0, 32'sd0, 1'b0},
		'{CH_MINUS,      1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_0 + 8'd5,   1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_DIVIDE,     1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_0 + 8'd2,   1'b1, 1'b0, 32'sd0, 1'b0},
		'{CH_NOISE,      1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_0 + 8'd5,   1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_PLUS,       1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_PLUS,       1'b1, 1'b0, 32'sd0, 1'b0},
		'{CH_NUL,        1'b0, 1'b0, 32'sd0, 1'b0},
		'{CH_0 + 8'd8,   1'b1, 1'b0, 32'sd0, 1'b0}
	};

	logic [7:0] op_chars [0:3] = '{CH_PLUS, CH_MINUS, CH_TIMES, CH_DIVIDE};

	logic      clk;
	logic      arst_n;
	logic      char_valid;
	logic      char_stall;
	char_req_t char_req;
	logic      result_valid;
	logic      result_stall;
	result_t   result;

	// evaluator state mirrored by the bench
	logic [31:0] sum_total;
	logic [31:0] term_acc;
	logic [31:0] num_acc;
	op_t         op_held;
	logic        div_err;

	result_t    expected_values [$];
	logic [7:0] expr_chars [$];
	result_t    want;
	int         burst_left;
	int         errors;
	int         cycle_count;
	int         stall_cycle;
	int         stall_mode;

	infix_expression_evaluator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_req     (char_req),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	task automatic clear_eval();
		sum_total = '0;
		term_acc  = '0;
		num_acc   = '0;
		op_held   = OP_PLUS;
		div_err   = 1'b0;
	endtask

	task automatic apply_char(input char_req_t req, output bit done, output result_t res);
		bit     is_op;
		op_t    next_op;
		longint quot;
		is_op   = 1'b1;
		next_op = OP_PLUS;
		case (req.ch)
			CH_PLUS:   next_op = OP_PLUS;
			CH_MINUS:  next_op = OP_MINUS;
			CH_TIMES:  next_op = OP_TIMES;
			CH_DIVIDE: next_op = OP_DIVIDE;
			default:   is_op = 1'b0;
		endcase
		if (req.ch >= CH_0 && req.ch <= CH_9)
			num_acc = num_acc * 32'd10 + {24'd0, req.ch - CH_0};
		if (is_op || req.last) begin
			case (op_held)
				OP_PLUS: begin
					sum_total = sum_total + term_acc;
					term_acc  = num_acc;
				end
				OP_MINUS: begin
					sum_total = sum_total + term_acc;
					term_acc  = -num_acc;
				end
				OP_TIMES: term_acc = term_acc * num_acc;
				default: begin
					if (num_acc == '0) begin
						term_acc = '0;
						div_err  = 1'b1;
					end else begin
						quot     = longint'($signed(term_acc)) / longint'($signed(num_acc));
						term_acc = quot[31:0];
					end
				end
			endcase
			num_acc = '0;
			if (is_op)
				op_held = next_op;
		end
		done         = req.last;
		res.value    = sum_total + term_acc;
		res.div_zero = div_err;
		if (req.last)
			clear_eval();
	endtask

	task automatic send_char(input char_req_t req, input bit typed, input result_t typed_res);
		int      gap;
		bit      done;
		result_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 4);
			if (gap != 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		char_req   <= req;
		char_valid <= 1'b1;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		apply_char(req, done, predicted);
		if (done)
			expected_values.push_back(typed ? typed_res : predicted);
	endtask

	task automatic push_number(input longint unsigned n);
		logic [7:0] digs [$];
		do begin
			digs.push_front(CH_0 + 8'(n % 64'd10));
			n = n / 64'd10;
		end while (n != 0);
		foreach (digs[i])
			expr_chars.push_back(digs[i]);
	endtask

	function automatic longint unsigned pick_number();
		longint unsigned wide;
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 9);
			6, 7, 8:          return $urandom_range(0, 999);
			9:                return 0;
			10:               return $urandom_range(0, 99999);
			11: begin
				case ($urandom_range(0, 3))
					0:       return 64'd2147483647;
					1:       return 64'd2147483648;
					2:       return 64'd4294967295;
					default: return 64'd4294967296;
				endcase
			end
			12, 13:           return $urandom;
			default: begin
				wide = {$urandom, $urandom};
				return wide % 64'd1000000000000;
			end
		endcase
	endfunction

	task automatic build_expr();
		int kind;
		int nterms;
		expr_chars.delete();
		kind = $urandom_range(0, 39);
		if (kind == 0) begin
			// most negative divided by minus one
			expr_chars.push_back(CH_MINUS);
			push_number(64'd2147483648);
			expr_chars.push_back(CH_DIVIDE);
			push_number(64'd4294967295);
		end else if (kind < 3) begin
			repeat ($urandom_range(1, 6))
				expr_chars.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 9) == 0)
				expr_chars.push_back(op_chars[$urandom_range(0, 3)]);
			nterms = $urandom_range(1, 6);
			for (int i = 0; i < nterms; i++) begin
				if ($urandom_range(0, 11) == 0)
					expr_chars.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 3) == 0)
					expr_chars.push_back(CH_SPACE);
				push_number(pick_number());
				if ($urandom_range(0, 3) == 0)
					expr_chars.push_back(CH_SPACE);
				if (i < nterms - 1) begin
					expr_chars.push_back(op_chars[$urandom_range(0, 3)]);
					if ($urandom_range(0, 14) == 0)
						expr_chars.push_back(op_chars[$urandom_range(0, 3)]);
				end
			end
			if ($urandom_range(0, 9) == 0)
				expr_chars.push_back(op_chars[$urandom_range(0, 3)]);
		end
	endtask

	// receiver stall patterns, with one long hold-off to back the block up
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		if (stall_cycle % 128 == 0)
			stall_mode <= $urandom_range(0, 3);
		if (stall_cycle >= HOLD_START && stall_cycle < HOLD_START + HOLD_LEN)
			result_stall <= 1'b1;
		else begin
			case (stall_mode)
				0:       result_stall <= 1'b0;
				1:       result_stall <= ($urandom_range(0, 3) == 0);
				2:       result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= (stall_cycle % 5 < 2);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_values.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: value=%0d div_zero=%0b",
					$time, result.value, result.div_zero);
			end else begin
				want = expected_values.pop_front();
				if (result.value !== want.value) begin
					errors++;
					$display("%0t: value mismatch: expected %0d, got %0d",
						$time, want.value, result.value);
				end
				if (result.div_zero !== want.div_zero) begin
					errors++;
					$display("%0t: div_zero mismatch: expected %0b, got %0b",
						$time, want.div_zero, result.div_zero);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("infix_expression_evaluator_tb NOT OK");
			$finish;
		end
	end

	initial begin
		char_req_t req;
		result_t   typed_res;
		int        sent;
		bit        drained;
		clk          = 1'b0;
		arst_n       = 1'b0;
		char_valid   = 1'b0;
		char_req     = '0;
		result_stall = 1'b0;
		stall_cycle  = 0;
		stall_mode   = 0;
		burst_left   = 0;
		errors       = 0;
		cycle_count  = 0;
		sent         = 0;
		drained      = 1'b0;
		clear_eval();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			req.ch             = dir_rows[i].ch;
			req.last           = dir_rows[i].last;
			typed_res.value    = dir_rows[i].value;
			typed_res.div_zero = dir_rows[i].div_zero;
			send_char(req, dir_rows[i].typed, typed_res);
		end

		while (sent < RANDOM_ITEMS) begin
			build_expr();
			foreach (expr_chars[i]) begin
				req.ch   = expr_chars[i];
				req.last = (i == expr_chars.size() - 1);
				send_char(req, 1'b0, '0);
			end
			sent += expr_chars.size();
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				drained = 1'b1;
				char_valid <= 1'b0;
				do @(posedge clk); while (expected_values.size() != 0);
			end
		end

		char_valid <= 1'b0;
		do @(posedge clk); while (expected_values.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_values.size() == 0)
			$display("infix_expression_evaluator_tb OK");
		else
			$display("infix_expression_evaluator_tb NOT OK");
		$finish;
	end

endmodule
